[rtl/particle_contact_impulse_resolver_macros.svh]
// Assertion helpers for the checker file.
`ifndef PARTICLE_CONTACT_IMPULSE_RESOLVER_MACROS_SVH
`define PARTICLE_CONTACT_IMPULSE_RESOLVER_MACROS_SVH

// Check a property outside reset.
`define PCIR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PCIR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pcir_pkg.sv]
package pcir_pkg;

   localparam int VW        = 32;
   localparam int NW        = 18;
   localparam int PW        = 51;
   localparam int SW        = 33;
   localparam int RW        = 34;
   localparam int QW        = 25;
   localparam int DIV_STEPS = QW;
   localparam int JW        = 40;
   localparam int QDEPTH    = 4;
   localparam int QPW       = $clog2(QDEPTH);
   localparam logic [16:0] RESTITUTION_RESET = 17'h10000;

   typedef struct packed {
      logic [2:0][VW-1:0] v1;
      logic [2:0][VW-1:0] v2;
      logic [2:0][NW-1:0] n;
      logic [2:0][PW-1:0] prod;
      logic [SW-1:0]      sum;
      logic [VW-1:0]      im1;
      logic [VW-1:0]      pen;
      logic               zero_sum;
      logic               pen_pos;
   } pcir_item_type;

   typedef struct packed {
      logic [2:0][VW-1:0] v1;
      logic [2:0][VW-1:0] v2;
      logic [2:0][NW-1:0] n;
      logic [36:0]        dot16;
      logic [JW-1:0]      j;
      logic [SW-1:0]      sum;
      logic [RW-1:0]      rem;
      logic [QW-1:0]      q;
      logic [VW-1:0]      pen;
      logic               zero_sum;
      logic               pen_pos;
   } pcir_div_type;

   typedef struct packed {
      logic [2:0][VW-1:0] v1;
      logic [2:0][VW-1:0] v2;
      logic [2:0][NW-1:0] n;
      logic [JW-1:0]      j;
      logic [QW-1:0]      r1;
      logic [QW-1:0]      r2;
      logic [VW-1:0]      pen;
      logic               zero_sum;
      logic               pen_pos;
   } pcir_ratio_type;

   typedef struct packed {
      logic [2:0][VW-1:0] v1;
      logic [2:0][VW-1:0] v2;
      logic [2:0][NW-1:0] n;
      logic [44:0]        jl_r1;
      logic [45:0]        jh_r1;
      logic [44:0]        jl_r2;
      logic [45:0]        jh_r2;
      logic [57:0]        dr1;
      logic [57:0]        dr2;
      logic               zero_sum;
      logic               pen_pos;
   } pcir_part_type;

   typedef struct packed {
      logic [2:0][VW-1:0] v1;
      logic [2:0][VW-1:0] v2;
      logic [2:0][NW-1:0] n;
      logic [JW-1:0]      m1;
      logic [JW-1:0]      m2;
      logic [33:0]        p1;
      logic [33:0]        p2;
      logic               zero_sum;
      logic               pen_pos;
   } pcir_scale_type;

   typedef struct packed {
      logic [2:0][VW-1:0] v1;
      logic [2:0][VW-1:0] v2;
      logic [2:0][41:0]   dv1;
      logic [2:0][41:0]   dv2;
      logic [2:0][35:0]   ds1;
      logic [2:0][35:0]   ds2;
      logic               zero_sum;
      logic               pen_pos;
   } pcir_delta_type;

   typedef struct packed {
      logic [2:0][VW-1:0] nv1;
      logic [2:0][VW-1:0] nv2;
      logic [2:0][VW-1:0] s1;
      logic [2:0][VW-1:0] s2;
   } pcir_result_type;

   function automatic logic [VW-1:0] sat32(input logic signed [43:0] x);
      logic [VW-1:0] r;
      if (x > 44'sd2147483647) begin
         r = 32'h7fffffff;
      end else if (x < -44'sd2147483648) begin
         r = 32'h80000000;
      end else begin
         r = x[VW-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/pcir_front.sv]
module pcir_front import pcir_pkg::*; (
   input  logic [2:0][VW-1:0] v1,
   input  logic [2:0][VW-1:0] v2,
   input  logic [2:0][NW-1:0] n,
   input  logic [VW-1:0]      im1,
   input  logic [VW-1:0]      im2,
   input  logic [VW-1:0]      pen,
   output pcir_item_type      item
);

   always_comb begin
      logic signed [32:0] diff;
      item.v1  = v1;
      item.v2  = v2;
      item.n   = n;
      item.im1 = im1;
      item.pen = pen;
      for (int i = 0; i < 3; i++) begin
         diff = 33'($signed(v1[i])) - 33'($signed(v2[i]));
         item.prod[i] = PW'(diff * $signed(n[i]));
      end
      item.sum      = {1'b0, im1} + {1'b0, im2};
      item.zero_sum = (item.sum == '0);
      item.pen_pos  = !pen[VW-1] && (pen != '0);
   end

endmodule

[rtl/pcir_queue.sv]
module pcir_queue import pcir_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  pcir_item_type push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output pcir_item_type pop_data
);

   pcir_item_type  mem_ff [QDEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPW:0]   count_ff, count_in;
   logic           push, pop;

   assign push_ready = (count_ff != (QPW+1)'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPW+1)'(push) - (QPW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/pcir_back.sv]
module pcir_back import pcir_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [16:0]     restitution,
   input  logic            in_valid,
   output logic            in_ready,
   input  pcir_item_type   in_item,
   output logic            out_valid,
   input  logic            out_ready,
   output pcir_result_type out_data
);

   pcir_div_type    div_ff [DIV_STEPS];
   pcir_div_type    div_in [DIV_STEPS];
   logic [DIV_STEPS-1:0] div_valid_ff;
   pcir_ratio_type  ra_ff, ra_in;
   pcir_part_type   pb_ff, pb_in;
   pcir_scale_type  pc_ff, pc_in;
   pcir_delta_type  pd_ff, pd_in;
   pcir_result_type out_ff, out_in;
   logic [4:0]      tail_valid_ff;
   logic            adv;

   // Whole pipeline moves together; it holds only while the result waits.
   assign adv       = !tail_valid_ff[4] || out_ready;
   assign in_ready  = adv;
   assign out_valid = tail_valid_ff[4];
   assign out_data  = out_ff;

   // First divider step: dot product and the integer quotient bit.
   always_comb begin
      logic signed [52:0] dot;
      dot = 53'($signed(in_item.prod[0])) + 53'($signed(in_item.prod[1]))
          + 53'($signed(in_item.prod[2]));
      div_in[0].v1       = in_item.v1;
      div_in[0].v2       = in_item.v2;
      div_in[0].n        = in_item.n;
      div_in[0].dot16    = dot[52:16];
      div_in[0].j        = '0;
      div_in[0].sum      = in_item.sum;
      div_in[0].pen      = in_item.pen;
      div_in[0].zero_sum = in_item.zero_sum;
      div_in[0].pen_pos  = in_item.pen_pos;
      div_in[0].q        = '0;
      if ({1'b0, in_item.im1} >= in_item.sum) begin
         div_in[0].rem       = RW'({1'b0, in_item.im1} - in_item.sum);
         div_in[0].q[QW-1]   = 1'b1;
      end else begin
         div_in[0].rem = RW'(in_item.im1);
      end
   end

   for (genvar k = 1; k < DIV_STEPS; k++) begin : g_div
      always_comb begin
         logic [RW-1:0]      rem2;
         logic signed [55:0] tj;
         div_in[k] = div_ff[k-1];
         rem2 = {div_ff[k-1].rem[RW-2:0], 1'b0};
         if (rem2 >= RW'(div_ff[k-1].sum)) begin
            div_in[k].rem        = rem2 - RW'(div_ff[k-1].sum);
            div_in[k].q[QW-1-k]  = 1'b1;
         end else begin
            div_in[k].rem = rem2;
         end
         tj = $signed(div_ff[k-1].dot16)
            * $signed({2'b00, restitution} + 19'h10000);
         if (k == 1) begin
            div_in[k].j = tj[55:16];
         end
      end
   end

   always_comb begin
      ra_in.v1       = div_ff[DIV_STEPS-1].v1;
      ra_in.v2       = div_ff[DIV_STEPS-1].v2;
      ra_in.n        = div_ff[DIV_STEPS-1].n;
      ra_in.j        = div_ff[DIV_STEPS-1].j;
      ra_in.pen      = div_ff[DIV_STEPS-1].pen;
      ra_in.zero_sum = div_ff[DIV_STEPS-1].zero_sum;
      ra_in.pen_pos  = div_ff[DIV_STEPS-1].pen_pos;
      ra_in.r1       = div_ff[DIV_STEPS-1].q;
      // Second fraction is the complement, one lower when the split is inexact.
      ra_in.r2       = (QW'(1) << (QW-1)) - div_ff[DIV_STEPS-1].q
                     - QW'(|div_ff[DIV_STEPS-1].rem);
   end

   always_comb begin
      pb_in.v1       = ra_ff.v1;
      pb_in.v2       = ra_ff.v2;
      pb_in.n        = ra_ff.n;
      pb_in.zero_sum = ra_ff.zero_sum;
      pb_in.pen_pos  = ra_ff.pen_pos;
      pb_in.jl_r1    = ra_ff.j[19:0] * ra_ff.r1;
      pb_in.jl_r2    = ra_ff.j[19:0] * ra_ff.r2;
      pb_in.jh_r1    = $signed(ra_ff.j[JW-1:20]) * $signed({1'b0, ra_ff.r1});
      pb_in.jh_r2    = $signed(ra_ff.j[JW-1:20]) * $signed({1'b0, ra_ff.r2});
      pb_in.dr1      = $signed(ra_ff.pen) * $signed({1'b0, ra_ff.r1});
      pb_in.dr2      = $signed(ra_ff.pen) * $signed({1'b0, ra_ff.r2});
   end

   always_comb begin
      logic [65:0] f1, f2;
      f1 = {pb_ff.jh_r1, 20'b0} + {21'b0, pb_ff.jl_r1};
      f2 = {pb_ff.jh_r2, 20'b0} + {21'b0, pb_ff.jl_r2};
      pc_in.v1       = pb_ff.v1;
      pc_in.v2       = pb_ff.v2;
      pc_in.n        = pb_ff.n;
      pc_in.zero_sum = pb_ff.zero_sum;
      pc_in.pen_pos  = pb_ff.pen_pos;
      pc_in.m1       = f1[63:24];
      pc_in.m2       = f2[63:24];
      pc_in.p1       = pb_ff.dr1[57:24];
      pc_in.p2       = pb_ff.dr2[57:24];
   end

   always_comb begin
      logic signed [57:0] tm1, tm2;
      logic signed [51:0] tp1, tp2;
      pd_in.v1       = pc_ff.v1;
      pd_in.v2       = pc_ff.v2;
      pd_in.zero_sum = pc_ff.zero_sum;
      pd_in.pen_pos  = pc_ff.pen_pos;
      for (int i = 0; i < 3; i++) begin
         tm1 = $signed(pc_ff.m1) * $signed(pc_ff.n[i]);
         tm2 = $signed(pc_ff.m2) * $signed(pc_ff.n[i]);
         tp1 = $signed(pc_ff.p1) * $signed(pc_ff.n[i]);
         tp2 = $signed(pc_ff.p2) * $signed(pc_ff.n[i]);
         pd_in.dv1[i] = tm1[57:16];
         pd_in.dv2[i] = tm2[57:16];
         pd_in.ds1[i] = tp1[51:16];
         pd_in.ds2[i] = tp2[51:16];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pd_ff.zero_sum) begin
            out_in.nv1[i] = pd_ff.v1[i];
            out_in.nv2[i] = pd_ff.v2[i];
         end else begin
            out_in.nv1[i] = sat32(44'($signed(pd_ff.v1[i])) - 44'($signed(pd_ff.dv1[i])));
            out_in.nv2[i] = sat32(44'($signed(pd_ff.v2[i])) + 44'($signed(pd_ff.dv2[i])));
         end
         if (pd_ff.pen_pos && !pd_ff.zero_sum) begin
            out_in.s1[i] = sat32(44'($signed(pd_ff.ds1[i])));
            out_in.s2[i] = sat32(-44'($signed(pd_ff.ds2[i])));
         end else begin
            out_in.s1[i] = '0;
            out_in.s2[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff  <= '0;
         tail_valid_ff <= '0;
      end else if (adv) begin
         div_valid_ff  <= {div_valid_ff[DIV_STEPS-2:0], in_valid};
         tail_valid_ff <= {tail_valid_ff[3:0], div_valid_ff[DIV_STEPS-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            div_ff[k] <= div_in[k];
         end
         ra_ff  <= ra_in;
         pb_ff  <= pb_in;
         pc_ff  <= pc_in;
         pd_ff  <= pd_in;
         out_ff <= out_in;
      end
   end

endmodule

[rtl/particle_contact_impulse_resolver.sv]
// Particle contact impulse resolver.
// Request channel (req_valid/req_ready) carries one contact: both velocities,
// both inverse masses and the penetration depth, Q16.16; the normal, Q2.16.
// Response channel (rsp_valid/rsp_ready) returns both new velocities and both
// position shifts, saturated to 32 bits, one response per request, in order.
// csr_wr_en/csr_wr_data write the restitution coefficient (reset value 1.0);
// write it only while no request is in flight.
// Throughput: one request per cycle while rsp_ready is high. A request passes
// through the queue, the 25-step pipelined mass-ratio divider and the
// partial-product multiply stages behind it.
// A four-entry queue sits between the front classifier and the back pipeline.
// When rsp_ready is low and a response is waiting, the back pipeline holds
// in place; the queue then fills and req_ready drops once it is full.
// Reset is synchronous, active high: it empties the queue and the pipeline,
// and restores restitution to 1.0. req_ready is high in the cycle after reset.
module particle_contact_impulse_resolver import pcir_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [31:0]   req_first_vel_x,
   input  logic [31:0]   req_first_vel_y,
   input  logic [31:0]   req_first_vel_z,
   input  logic [31:0]   req_second_vel_x,
   input  logic [31:0]   req_second_vel_y,
   input  logic [31:0]   req_second_vel_z,
   input  logic [17:0]   req_normal_x,
   input  logic [17:0]   req_normal_y,
   input  logic [17:0]   req_normal_z,
   input  logic [31:0]   req_first_inv_mass,
   input  logic [31:0]   req_second_inv_mass,
   input  logic [31:0]   req_penetration,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [31:0]   rsp_new_first_vel_x,
   output logic [31:0]   rsp_new_first_vel_y,
   output logic [31:0]   rsp_new_first_vel_z,
   output logic [31:0]   rsp_new_second_vel_x,
   output logic [31:0]   rsp_new_second_vel_y,
   output logic [31:0]   rsp_new_second_vel_z,
   output logic [31:0]   rsp_first_shift_x,
   output logic [31:0]   rsp_first_shift_y,
   output logic [31:0]   rsp_first_shift_z,
   output logic [31:0]   rsp_second_shift_x,
   output logic [31:0]   rsp_second_shift_y,
   output logic [31:0]   rsp_second_shift_z,
   input  logic          csr_wr_en,
   input  logic [16:0]   csr_wr_data
);

   logic [16:0]     rest_ff, rest_in;
   pcir_item_type   front_item, q_item;
   logic            q_valid, q_ready;
   pcir_result_type res;

   always_comb begin
      rest_in = csr_wr_en ? csr_wr_data : rest_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= RESTITUTION_RESET;
      end else begin
         rest_ff <= rest_in;
      end
   end

   pcir_front u_front (
      .v1   ({req_first_vel_z, req_first_vel_y, req_first_vel_x}),
      .v2   ({req_second_vel_z, req_second_vel_y, req_second_vel_x}),
      .n    ({req_normal_z, req_normal_y, req_normal_x}),
      .im1  (req_first_inv_mass),
      .im2  (req_second_inv_mass),
      .pen  (req_penetration),
      .item (front_item)
   );

   pcir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_item)
   );

   pcir_back u_back (
      .clock       (clock),
      .reset       (reset),
      .restitution (rest_ff),
      .in_valid    (q_valid),
      .in_ready    (q_ready),
      .in_item     (q_item),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_data    (res)
   );

   assign rsp_new_first_vel_x  = res.nv1[0];
   assign rsp_new_first_vel_y  = res.nv1[1];
   assign rsp_new_first_vel_z  = res.nv1[2];
   assign rsp_new_second_vel_x = res.nv2[0];
   assign rsp_new_second_vel_y = res.nv2[1];
   assign rsp_new_second_vel_z = res.nv2[2];
   assign rsp_first_shift_x    = res.s1[0];
   assign rsp_first_shift_y    = res.s1[1];
   assign rsp_first_shift_z    = res.s1[2];
   assign rsp_second_shift_x   = res.s2[0];
   assign rsp_second_shift_y   = res.s2[1];
   assign rsp_second_shift_z   = res.s2[2];

endmodule

[rtl/pcir_checker.sv]
`include "particle_contact_impulse_resolver_macros.svh"

module pcir_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_new_first_vel_x,
   input logic [31:0] rsp_first_shift_x
);

   `PCIR_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp_valid after reset")
   `PCIR_ASSERT_ALWAYS(a_reset_opens_req, clock, reset |=> req_ready, "req_ready low after reset")
   `PCIR_ASSERT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")
   `PCIR_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_new_first_vel_x) && $stable(rsp_first_shift_x), "stalled response changed")

endmodule

bind particle_contact_impulse_resolver pcir_checker u_pcir_checker (.*);
